// ===== src/shd_pkg.sv =====
// Shared types and constants of the step hit detector.
// Used by shd_cfg_regs, shd_step_logic and step_hit_detector_top; no dependencies.

package shd_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int HIT_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 16;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ARM_DELAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEN_MARGIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REQ_HITS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_MULT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_TRIG   = 3'd7;

	// reset values
	localparam logic [15:0] RST_ARM_DELAY  = 16'd250;
	localparam logic [15:0] RST_COOLDOWN   = 16'd1000;
	localparam logic [14:0] RST_TORQUE_THR = 15'd2560;
	localparam logic [15:0] RST_MAX_LENGTH = 16'd26214;
	localparam logic [15:0] RST_LEN_MARGIN = 16'd1311;
	localparam logic [7:0]  RST_REQ_HITS   = 8'd10;
	localparam logic [2:0]  RST_SAT_MULT   = 3'd2;
	localparam logic        RST_AUTO_TRIG  = 1'b0;

	typedef struct packed {
		logic [15:0] arm_delay_length;
		logic [15:0] cooldown_length;
		logic [14:0] torque_threshold;
		logic [15:0] maximum_leg_length;
		logic [15:0] length_margin;
		logic [7:0]  required_hits;
		logic [2:0]  saturation_multiple;
		logic        auto_trigger_enable;
	} shd_cfg_t;

	typedef struct packed {
		logic               cooldown_refresh;
		logic        [15:0] right_length;
		logic        [15:0] left_length;
		logic signed [15:0] right_torque;
		logic signed [15:0] left_torque;
		logic               retract_active;
		logic               start_active;
		logic               long_leg_target;
	} shd_item_t;

	typedef struct packed {
		logic [HIT_W-1:0] hit_level;
		logic             detected;
		logic             stair_request;
	} shd_result_t;

endpackage

// ===== src/shd_cfg_regs.sv =====
// Configuration register file of the step hit detector.
// Depends on shd_pkg.

module shd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [shd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [shd_pkg::CFG_DATA_W-1:0] cfg_data,
	output shd_pkg::shd_cfg_t              cfg
);

	shd_pkg::shd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_delay_length    <= shd_pkg::RST_ARM_DELAY;
			cfg_q.cooldown_length     <= shd_pkg::RST_COOLDOWN;
			cfg_q.torque_threshold    <= shd_pkg::RST_TORQUE_THR;
			cfg_q.maximum_leg_length  <= shd_pkg::RST_MAX_LENGTH;
			cfg_q.length_margin       <= shd_pkg::RST_LEN_MARGIN;
			cfg_q.required_hits       <= shd_pkg::RST_REQ_HITS;
			cfg_q.saturation_multiple <= shd_pkg::RST_SAT_MULT;
			cfg_q.auto_trigger_enable <= shd_pkg::RST_AUTO_TRIG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				shd_pkg::REG_ARM_DELAY:  cfg_q.arm_delay_length    <= cfg_data;
				shd_pkg::REG_COOLDOWN:   cfg_q.cooldown_length     <= cfg_data;
				shd_pkg::REG_TORQUE_THR: cfg_q.torque_threshold    <= cfg_data[14:0];
				shd_pkg::REG_MAX_LENGTH: cfg_q.maximum_leg_length  <= cfg_data;
				shd_pkg::REG_LEN_MARGIN: cfg_q.length_margin       <= cfg_data;
				shd_pkg::REG_REQ_HITS:   cfg_q.required_hits       <= cfg_data[7:0];
				shd_pkg::REG_SAT_MULT:   cfg_q.saturation_multiple <= cfg_data[2:0];
				shd_pkg::REG_AUTO_TRIG:  cfg_q.auto_trigger_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/shd_step_logic.sv =====
// Per-tick update: arm delay, cooldown and hit counters plus the detection decision.
// Depends on shd_pkg.

module shd_step_logic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  shd_pkg::shd_item_t    item,
	input  shd_pkg::shd_cfg_t     cfg,
	output shd_pkg::shd_result_t  result
);

	localparam int TW = shd_pkg::TIMER_WIDTH;
	localparam int HW = shd_pkg::HIT_W;

	logic          was_long_q;
	logic [TW-1:0] arm_q;
	logic [TW-1:0] cool_q;
	logic [HW-1:0] hit_q;

	logic [TW-1:0] arm_base, arm_next;
	logic [TW-1:0] cool_base, cool_dec, cool_next;
	logic [TW-1:0] cool_load;
	logic [16:0]   len_diff;
	logic [15:0]   len_thr;
	logic [16:0]   left_mag, right_mag;
	logic          left_hit, right_hit, gate_open;
	logic [10:0]   ceil_full;
	logic [HW-1:0] ceiling;
	logic [HW-1:0] hit_upd, hit_next;
	logic          det;

	assign cool_load = TW'(cfg.cooldown_length);

	always_comb begin
		// arm delay: load on rising long-leg, cleared when short
		arm_base = (!was_long_q) ? TW'(cfg.arm_delay_length) : arm_q;
		if (!item.long_leg_target)
			arm_next = '0;
		else if (arm_base != '0)
			arm_next = arm_base - TW'(1);
		else
			arm_next = arm_base;

		cool_base = item.cooldown_refresh ? cool_load : cool_q;
		cool_dec  = (cool_base != '0) ? cool_base - TW'(1) : cool_base;

		len_diff = {1'b0, cfg.maximum_leg_length} - {1'b0, cfg.length_margin};
		len_thr  = len_diff[16] ? 16'd0 : len_diff[15:0];

		// most negative torque yields 32768
		left_mag  = item.left_torque[15]  ? 17'h10000 - {1'b0, item.left_torque}
		                                  : {1'b0, item.left_torque};
		right_mag = item.right_torque[15] ? 17'h10000 - {1'b0, item.right_torque}
		                                  : {1'b0, item.right_torque};
		left_hit  = (left_mag  > {2'b00, cfg.torque_threshold}) && (item.left_length  > len_thr);
		right_hit = (right_mag > {2'b00, cfg.torque_threshold}) && (item.right_length > len_thr);

		ceil_full = 11'(cfg.required_hits) * 11'(cfg.saturation_multiple);
		ceiling   = ceil_full[10] ? shd_pkg::HIT_MAX : ceil_full[HW-1:0];

		gate_open = (cool_dec == '0) && (arm_next == '0) && left_hit && right_hit
		            && item.long_leg_target && item.start_active && !item.retract_active;

		if (gate_open)
			hit_upd = (hit_q < ceiling) ? hit_q + HW'(1) : hit_q;
		else
			hit_upd = (hit_q != '0) ? hit_q - HW'(1) : hit_q;

		det       = {2'b00, hit_upd} >= {4'b0000, cfg.required_hits};
		hit_next  = det ? '0 : hit_upd;
		cool_next = det ? cool_load : cool_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_long_q <= 1'b0;
			arm_q      <= '0;
			cool_q     <= '0;
			hit_q      <= '0;
		end else if (step_en) begin
			was_long_q <= item.long_leg_target;
			arm_q      <= arm_next;
			cool_q     <= cool_next;
			hit_q      <= hit_next;
		end
	end

	assign result.stair_request = det & cfg.auto_trigger_enable;
	assign result.detected      = det;
	assign result.hit_level     = hit_next;

endmodule

// ===== src/step_hit_detector_top.sv =====
// Top level of the step hit detector: input register, step logic, result register.
// Depends on shd_pkg, shd_cfg_regs and shd_step_logic.

// One request per control tick enters the input register, is evaluated combinationally
// against the arm delay, cooldown and hit counters and lands in the result register,
// which drives m_tvalid; it moves on only while the result register is empty or draining,
// and a new request is taken every cycle as long as the result side keeps draining.
// The only loop is the update of the counters, so the sustained rate is one item per
// clock while the result side drains. Configuration writes take effect at the next
// clock edge and should be made with no request in flight.

module step_hit_detector_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [shd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [shd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] long_leg_target, [1] start_active, [2] retract_active, [18:3] left_torque,
	// [34:19] right_torque, [50:35] left_length, [66:51] right_length,
	// [67] cooldown_refresh, [71:68] zero
	input  logic [shd_pkg::IN_TDATA_W-1:0]    s_tdata,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] stair_request, [1] detected, [11:2] hit_level, [15:12] zero
	output logic [shd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int ITEM_W = $bits(shd_pkg::shd_item_t);
	localparam int RES_W  = $bits(shd_pkg::shd_result_t);

	shd_pkg::shd_cfg_t    cfg;
	shd_pkg::shd_item_t   item_s1;
	shd_pkg::shd_result_t result;
	shd_pkg::shd_result_t result_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 advance;

	shd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves into the result register when it is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= shd_pkg::shd_item_t'(s_tdata[ITEM_W-1:0]);
		if (advance)
			result_s2 <= result;
	end

	shd_step_logic u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(shd_pkg::OUT_TDATA_W - RES_W){1'b0}}, result_s2};

endmodule
